FILE: rtl/bst_pkg.sv
// Shared types, codes and helper functions of the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package bst_pkg;

  // Width of the internal line, column and length counters.
  localparam int POS_BITS = 16;
  // Width of the line, column and length fields on the result port.
  localparam int FIELD_W = 16;

  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam pos_t POS_ONE = pos_t'(1);
  localparam pos_t POS_MAX = {POS_BITS{1'b1}};

  // Token kinds.
  localparam logic [3:0] K_EOF    = 4'd0;
  localparam logic [3:0] K_NOT_OP = 4'd0;
  localparam logic [3:0] K_SEMI   = 4'd1;
  localparam logic [3:0] K_PLUS   = 4'd2;
  localparam logic [3:0] K_MINUS  = 4'd3;
  localparam logic [3:0] K_STAR   = 4'd4;
  localparam logic [3:0] K_SLASH  = 4'd5;
  localparam logic [3:0] K_LPAREN = 4'd6;
  localparam logic [3:0] K_RPAREN = 4'd7;
  localparam logic [3:0] K_EQUAL  = 4'd8;
  localparam logic [3:0] K_COLON  = 4'd9;
  localparam logic [3:0] K_COMMA  = 4'd10;
  localparam logic [3:0] K_INT    = 4'd11;
  localparam logic [3:0] K_DEC    = 4'd12;
  localparam logic [3:0] K_IDENT  = 4'd13;
  localparam logic [3:0] K_BAD    = 4'd14;
  localparam logic [3:0] K_LONE   = 4'd15;

  // Character codes.
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 1;

  typedef struct packed {
    logic [3:0] kind;
    field_t     line;
    field_t     col;
    field_t     len;
    logic       last;
  } tok_rec_t;

  // Up to two records caused by one accepted byte.
  typedef struct packed {
    logic [1:0] count;
    tok_rec_t   rec0;
    tok_rec_t   rec1;
  } tok_pair_t;

  function automatic pos_t sat_inc(input pos_t v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic field_t to_field(input pos_t v);
    return FIELD_W'(v);
  endfunction

  function automatic logic [3:0] op_kind(input logic [7:0] b);
    logic [3:0] k;
    case (b)
      CH_SEMI:   k = K_SEMI;
      CH_PLUS:   k = K_PLUS;
      CH_MINUS:  k = K_MINUS;
      CH_STAR:   k = K_STAR;
      CH_SLASH:  k = K_SLASH;
      CH_LPAREN: k = K_LPAREN;
      CH_RPAREN: k = K_RPAREN;
      CH_EQUAL:  k = K_EQUAL;
      CH_COLON:  k = K_COLON;
      CH_COMMA:  k = K_COMMA;
      default:   k = K_NOT_OP;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bst_result_fifo.sv
// Small result queue that takes up to two token records a cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module bst_result_fifo (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire bst_pkg::tok_pair_t        push,
  input  wire logic                      pop,
  output bst_pkg::tok_rec_t              head,
  output logic [bst_pkg::FIFO_CW-1:0]    count
);
  import bst_pkg::*;

  tok_rec_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_CW-1:0] count_next;
  logic do_pop;

  assign do_pop = pop && (count != '0);
  assign head = mem[rd_ptr];

  always_comb begin
    count_next = count + FIFO_CW'(push.count);
    if (do_pop) begin
      count_next = count_next - FIFO_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_AW'(push.count);
      if (do_pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.rec0;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_AW'(1)] <= push.rec1;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bst_lexer.sv
// Lexer state and the per-byte token logic of the byte stream tokenizer.
`timescale 1ns / 1ps
`default_nettype none

module bst_lexer (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [7:0]           char_byte,
  input  wire logic                 is_end,
  output bst_pkg::tok_pair_t        res
);
  import bst_pkg::*;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_NUM   = 2'd1;
  localparam logic [1:0] MODE_IDENT = 2'd2;
  localparam logic [1:0] MODE_ERR   = 2'd3;

  logic [1:0] mode, mode_next;
  logic       seen_point, seen_point_next;
  pos_t       token_line, token_line_next;
  pos_t       token_col, token_col_next;
  pos_t       token_len, token_len_next;
  pos_t       cur_line, cur_line_next;
  pos_t       cur_col, cur_col_next;

  logic       is_digit, is_dot, is_word, is_space;
  logic [3:0] opk;
  logic       lone;
  pos_t       mv_line, mv_col;
  tok_rec_t   flush_rec, eof_rec, idle_rec;
  logic       idle_emit, idle_start, idle_seen;
  logic [1:0] idle_mode;

  assign is_digit = (char_byte >= CH_ZERO) && (char_byte <= CH_NINE);
  assign is_dot   = (char_byte == CH_DOT);
  assign is_word  = ((char_byte >= CH_LO_A) && (char_byte <= CH_LO_Z)) ||
                    ((char_byte >= CH_UP_A) && (char_byte <= CH_UP_Z)) ||
                    (char_byte == CH_USCORE);
  assign is_space = (char_byte == CH_SPACE) ||
                    ((char_byte >= CH_TAB) && (char_byte <= CH_CR));
  assign opk      = op_kind(char_byte);
  assign lone     = seen_point && (token_len == POS_ONE);

  // Position of the byte after this one.
  always_comb begin
    if (char_byte == CH_NL) begin
      mv_line = sat_inc(cur_line);
      mv_col  = POS_ONE;
    end else begin
      mv_line = cur_line;
      mv_col  = sat_inc(cur_col);
    end
  end

  // Record for the pending run and for end of source.
  always_comb begin
    flush_rec.line = to_field(token_line);
    flush_rec.col  = to_field(token_col);
    flush_rec.len  = to_field(token_len);
    flush_rec.last = 1'b0;
    if (mode == MODE_IDENT) begin
      flush_rec.kind = K_IDENT;
    end else if (lone) begin
      flush_rec.kind = K_LONE;
    end else if (seen_point) begin
      flush_rec.kind = K_DEC;
    end else begin
      flush_rec.kind = K_INT;
    end
    eof_rec.kind = K_EOF;
    eof_rec.line = to_field(cur_line);
    eof_rec.col  = to_field(cur_col);
    eof_rec.len  = '0;
    eof_rec.last = 1'b0;
  end

  // What the byte does when no run is open.
  always_comb begin
    idle_mode     = MODE_IDLE;
    idle_seen     = 1'b0;
    idle_start    = 1'b0;
    idle_emit     = 1'b0;
    idle_rec.kind = K_BAD;
    idle_rec.line = to_field(cur_line);
    idle_rec.col  = to_field(cur_col);
    idle_rec.len  = FIELD_W'(1);
    idle_rec.last = 1'b0;
    if (is_space) begin
      idle_mode = MODE_IDLE;
    end else if (is_digit || is_dot) begin
      idle_mode  = MODE_NUM;
      idle_seen  = is_dot;
      idle_start = 1'b1;
    end else if (is_word) begin
      idle_mode  = MODE_IDENT;
      idle_start = 1'b1;
    end else if (opk != K_NOT_OP) begin
      idle_emit     = 1'b1;
      idle_rec.kind = opk;
    end else begin
      idle_emit = 1'b1;
      idle_mode = MODE_ERR;
    end
  end

  always_comb begin
    mode_next       = mode;
    seen_point_next = seen_point;
    token_line_next = token_line;
    token_col_next  = token_col;
    token_len_next  = token_len;
    cur_line_next   = cur_line;
    cur_col_next    = cur_col;
    res.count       = 2'd0;
    res.rec0        = flush_rec;
    res.rec1        = eof_rec;

    if (step) begin
      if (is_end) begin
        if ((mode == MODE_NUM) || (mode == MODE_IDENT)) begin
          res.count = 2'd2;
        end else begin
          res.rec0  = eof_rec;
          res.count = 2'd1;
        end
        mode_next       = MODE_IDLE;
        seen_point_next = 1'b0;
        token_line_next = POS_ONE;
        token_col_next  = POS_ONE;
        token_len_next  = '0;
        cur_line_next   = POS_ONE;
        cur_col_next    = POS_ONE;
      end else begin
        cur_line_next = mv_line;
        cur_col_next  = mv_col;
        case (mode)
          MODE_ERR: begin
          end
          MODE_NUM: begin
            if (is_digit) begin
              token_len_next = sat_inc(token_len);
            end else if (is_dot && !seen_point) begin
              seen_point_next = 1'b1;
              token_len_next  = sat_inc(token_len);
            end else if (lone) begin
              // A point alone is an error, and the byte that ends it is dropped.
              res.count = 2'd1;
              mode_next = MODE_ERR;
            end else begin
              res.rec1  = idle_rec;
              res.count = idle_emit ? 2'd2 : 2'd1;
              mode_next       = idle_mode;
              seen_point_next = idle_seen;
            end
          end
          MODE_IDENT: begin
            if (is_word) begin
              token_len_next = sat_inc(token_len);
            end else begin
              res.rec1  = idle_rec;
              res.count = idle_emit ? 2'd2 : 2'd1;
              mode_next       = idle_mode;
              seen_point_next = idle_seen;
            end
          end
          default: begin
            res.rec0  = idle_rec;
            res.count = idle_emit ? 2'd1 : 2'd0;
            mode_next       = idle_mode;
            seen_point_next = idle_seen;
          end
        endcase
        // A new run starts at the position of this byte.
        if (idle_start && (mode_next == idle_mode) && (res.count != 2'd0 ||
            mode == MODE_IDLE) && !(mode == MODE_NUM && lone)) begin
          token_line_next = cur_line;
          token_col_next  = cur_col;
          token_len_next  = POS_ONE;
        end
      end
    end

    if (res.count == 2'd1) begin
      res.rec0.last = 1'b1;
    end
    if (res.count == 2'd2) begin
      res.rec1.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      seen_point <= 1'b0;
      token_line <= POS_ONE;
      token_col  <= POS_ONE;
      token_len  <= '0;
      cur_line   <= POS_ONE;
      cur_col    <= POS_ONE;
    end else begin
      mode       <= mode_next;
      seen_point <= seen_point_next;
      token_line <= token_line_next;
      token_col  <= token_col_next;
      token_len  <= token_len_next;
      cur_line   <= cur_line_next;
      cur_col    <= cur_col_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/byte_stream_tokenizer.sv
// Top level of the byte stream tokenizer: byte channel in, token record channel out.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                Payload
// source    src_valid / src_ready    char_byte, is_end
// tokens    tok_valid / tok_ready    token_kind, begin_line, begin_col, token_length,
//                                    last_of_item
//
// One source byte is taken per clock cycle while src_ready is high. The lexer
// state updates at the edge that accepts the byte, and the records it causes
// enter a four-entry result queue in that same edge; the head of the queue
// drives the token port. A byte that closes a run other than a lone point and
// is itself an operator or a bad byte causes two records, which leave one at a time.
// Reset is synchronous and active high; it empties the queue and sets the
// position to line 1, column 1 with no run open.
// The source side stalls only when fewer than two queue entries are free.
module byte_stream_tokenizer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        src_valid,
  output logic             src_ready,
  input  wire logic [7:0]  char_byte,
  input  wire logic        is_end,
  output logic             tok_valid,
  input  wire logic        tok_ready,
  output logic [3:0]       token_kind,
  output logic [15:0]      begin_line,
  output logic [15:0]      begin_col,
  output logic [15:0]      token_length,
  output logic             last_of_item
);
  import bst_pkg::*;

  logic               accept;
  tok_pair_t          new_recs;
  tok_rec_t           head;
  logic [FIFO_CW-1:0] fifo_count;

  // Room for the worst case of two records from one transaction.
  assign src_ready = (fifo_count <= FIFO_CW'(FIFO_DEPTH - 2));
  assign accept    = src_valid && src_ready;

  bst_lexer u_lexer (
    .clk       (clk),
    .rst       (rst),
    .step      (accept),
    .char_byte (char_byte),
    .is_end    (is_end),
    .res       (new_recs)
  );

  bst_result_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (new_recs),
    .pop   (tok_ready),
    .head  (head),
    .count (fifo_count)
  );

  assign tok_valid    = (fifo_count != '0);
  assign token_kind   = head.kind;
  assign begin_line   = head.line;
  assign begin_col    = head.col;
  assign token_length = head.len;
  assign last_of_item = head.last;

  // The end transaction always produces at least the EOF record.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept && is_end |=> tok_valid)
    else $error("end transaction produced no token record");

  // EOF is always the final record of its transaction and has no length.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (token_kind == K_EOF) |-> last_of_item && (token_length == '0))
    else $error("EOF record not last or nonzero length");

  // The queue never holds more than its depth.
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= FIFO_CW'(FIFO_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire
